// ===== rtl/core/dsv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared constants, types and the month length table for the date string
// validator (DD.MM.YYYY, Gregorian calendar).
// ----------------------------------------------------------------------------
package dsv_pkg;

  // String layout
  localparam logic [3:0] DATE_LEN      = 4'd10;
  localparam logic [3:0] POS_SAT       = 4'd11;
  localparam logic [3:0] DOT_POS_DAY   = 4'd2;
  localparam logic [3:0] DOT_POS_MONTH = 4'd5;

  // Character codes
  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;

  // Calendar limits
  localparam logic [7:0] DAY_MAX      = 8'd31;
  localparam logic [7:0] MONTH_MAX    = 8'd12;
  localparam logic [7:0] DAY_SAFE_MAX = 8'd28;
  localparam logic [7:0] MONTH_FEB    = 8'd2;

  // Collected fields of one string, as held after the current item
  typedef struct packed {
    logic        fmt_err;
    logic [3:0]  pos;
    logic [7:0]  day_bcd;
    logic [7:0]  month_bcd;
    logic [15:0] year_bcd;
  } dsv_fields_t;

  // Days in a month, February counted as 29; index is month minus one
  function automatic logic [7:0] month_days(input logic [3:0] idx);
    logic [7:0] d;
    case (idx)
      4'd0:    d = 8'd31;
      4'd1:    d = 8'd29;
      4'd2:    d = 8'd31;
      4'd3:    d = 8'd30;
      4'd4:    d = 8'd31;
      4'd5:    d = 8'd30;
      4'd6:    d = 8'd31;
      4'd7:    d = 8'd31;
      4'd8:    d = 8'd30;
      4'd9:    d = 8'd31;
      4'd10:   d = 8'd30;
      4'd11:   d = 8'd31;
      default: d = 8'd31;
    endcase
    return d;
  endfunction

  // Two BCD digits to binary, by shift and add
  function automatic logic [7:0] bcd2_val(input logic [7:0] b);
    logic [7:0] t;
    logic [7:0] o;
    t = {4'd0, b[7:4]};
    o = {4'd0, b[3:0]};
    return (t << 3) + (t << 1) + o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dsv_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_if
// Valid/ready channels of the date string validator: character items in,
// verdict items out.
// ----------------------------------------------------------------------------
interface dsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_final_char;

  modport source (output valid, output char_code, output is_final_char, input ready);
  modport sink   (input valid, input char_code, input is_final_char, output ready);
endinterface

interface dsv_out_if;
  logic valid;
  logic ready;
  logic date_ok;

  modport source (output valid, output date_ok, input ready);
  modport sink   (input valid, input date_ok, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dsv_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_parser
// Input register for one character item, position counter, BCD digit
// registers and sticky format error. Presents the fields as they stand
// after the registered item.
// ----------------------------------------------------------------------------
module dsv_parser
  import dsv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char,
  input  wire logic        in_last,
  input  wire logic        out_free,
  output logic             fin,
  output dsv_fields_t      fields
);

  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  dsv_fields_t st_r;
  dsv_fields_t st_nxt;
  logic        adv;
  logic        is_digit;
  logic [3:0]  nib;

  // Advance the held item unless it is a last item facing a full output
  assign adv      = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || adv;
  assign fin      = adv && s1_last_r;
  assign fields   = st_nxt;

  // Classify the character and work out the state after it
  always_comb begin
    is_digit = s1_char_r inside {[CHAR_0:CHAR_9]};
    nib      = s1_char_r[3:0];
    st_nxt   = st_r;
    if (st_r.pos >= DATE_LEN) begin
      st_nxt.fmt_err = 1'b1;
    end else if (st_r.pos inside {DOT_POS_DAY, DOT_POS_MONTH}) begin
      if (s1_char_r != CHAR_DOT) st_nxt.fmt_err = 1'b1;
    end else begin
      if (!is_digit) st_nxt.fmt_err = 1'b1;
      if (st_r.pos < DOT_POS_DAY) begin
        st_nxt.day_bcd = {st_r.day_bcd[3:0], nib};
      end else if (st_r.pos < DOT_POS_MONTH) begin
        st_nxt.month_bcd = {st_r.month_bcd[3:0], nib};
      end else begin
        st_nxt.year_bcd = {st_r.year_bcd[11:0], nib};
      end
    end
    if (st_r.pos < POS_SAT) st_nxt.pos = st_r.pos + 4'd1;
  end

  // Hold the incoming item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_char_r <= in_char;
      s1_last_r <= in_last;
    end
  end

  // Commit the state, drop it after the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= s1_last_r ? '0 : st_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dsv_calendar.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_calendar
// Verdict on the collected fields: length, format and Gregorian calendar
// date check.
// ----------------------------------------------------------------------------
module dsv_calendar
  import dsv_pkg::*;
(
  input  wire dsv_fields_t fields,
  output logic             date_ok
);

  logic [7:0] day;
  logic [7:0] month;
  logic [7:0] yy;
  logic [7:0] cc;
  logic       leap;
  logic       range_ok;
  logic       len_ok;
  logic       cal_ok;

  // Decode the BCD fields
  assign day   = bcd2_val(fields.day_bcd);
  assign month = bcd2_val(fields.month_bcd);
  assign yy    = bcd2_val(fields.year_bcd[7:0]);
  assign cc    = bcd2_val(fields.year_bcd[15:8]);

  // A century year is leap when the century is a multiple of four
  assign leap = (yy == 8'd0) ? (cc[1:0] == 2'd0) : (yy[1:0] == 2'd0);

  assign range_ok = (day >= 8'd1) && (day <= DAY_MAX) &&
                    (month >= 8'd1) && (month <= MONTH_MAX);

  // Late days must fit the month, and 29 February needs a leap year
  assign len_ok = (day <= DAY_SAFE_MAX) ||
                  ((day <= month_days(month[3:0] - 4'd1)) &&
                   !((month == MONTH_FEB) && !leap));

  assign cal_ok  = range_ok && len_ok;
  assign date_ok = !fields.fmt_err && (fields.pos == DATE_LEN) && cal_ok;

endmodule
`default_nettype wire

// ===== rtl/core/date_string_validator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The verdict is registered in the output register as the last character leaves the input register.
// Throughput: one character item per cycle; the input register and the
// output register let a new item in while a verdict waits to be taken.
// Only a last character meeting a full, unread output register stalls input.
// Reset: synchronous, active low; clears the position, digits, error flag
// and both valid flags.
// ----------------------------------------------------------------------------
// date_string_validator
// Checks a DD.MM.YYYY date string, one character per item, and gives one
// verdict item per string on its last character.
// ----------------------------------------------------------------------------
module date_string_validator
  import dsv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  dsv_in_if.sink     in_chan,
  dsv_out_if.source  out_chan
);

  dsv_fields_t fields;
  logic        fin;
  logic        out_free;
  logic        ok;
  logic        out_valid_r;
  logic        out_date_ok_r;

  assign out_free = !out_valid_r || out_chan.ready;

  dsv_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_char  (in_chan.char_code),
    .in_last  (in_chan.is_final_char),
    .out_free (out_free),
    .fin      (fin),
    .fields   (fields)
  );

  dsv_calendar u_calendar (
    .fields  (fields),
    .date_ok (ok)
  );

  // Hold the verdict until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin;
    end
    if (fin) begin
      out_date_ok_r <= ok;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.date_ok = out_date_ok_r;

endmodule
`default_nettype wire
